/* sv/periodic_timer_scheduler_core_macros.svh */
// Assertion macros shared by the timer scheduler checkers.
// Depends on nothing; included by files that hold assertions.
`ifndef PERIODIC_TIMER_SCHEDULER_CORE_MACROS_SVH
`define PERIODIC_TIMER_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication
`define PTSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptsc assertion failed");

// next-cycle implication
`define PTSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptsc assertion failed");

`endif

/* sv/ptsc_pkg.sv */
// Package for the periodic timer scheduler: request and status codes, limits.
// No dependencies.
package ptsc_pkg;

  typedef logic [2:0] req_type_t;
  typedef logic [1:0] status_t;

  localparam req_type_t REQ_SCHED   = 3'd0;
  localparam req_type_t REQ_SET     = 3'd1;
  localparam req_type_t REQ_ADD     = 3'd2;
  localparam req_type_t REQ_RESTART = 3'd3;
  localparam req_type_t REQ_CANCEL  = 3'd4;
  localparam req_type_t REQ_QUERY   = 3'd5;
  localparam req_type_t REQ_TICK    = 3'd6;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BADARG   = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  localparam int ID_W      = 16;
  localparam int PERIOD_W  = 32;
  localparam int TIMES_W   = 17;
  localparam int ORD_W     = 16;
  localparam int MAX_FIRES = 16;
  localparam int FCNT_W    = $clog2(MAX_FIRES + 1);

endpackage

/* sv/ptsc_req_if.sv */
// Request channel of the timer scheduler.
// Depends on ptsc_pkg.
interface ptsc_req_if;
  logic                      valid;
  logic                      ready;
  ptsc_pkg::req_type_t       req_type;
  logic [15:0]               task_id;
  logic signed [31:0]        period_ms;
  logic signed [16:0]        execute_times;

  modport source (output valid, req_type, task_id, period_ms, execute_times, input ready);
  modport sink   (input valid, req_type, task_id, period_ms, execute_times, output ready);
endinterface

/* sv/ptsc_rsp_if.sv */
// Result channel of the timer scheduler.
// Depends on ptsc_pkg.
interface ptsc_rsp_if;
  logic                valid;
  logic                ready;
  ptsc_pkg::status_t   status;
  logic [15:0]         result_id;
  logic                fired;
  logic                is_scheduled;
  logic                last;

  modport source (output valid, status, result_id, fired, is_scheduled, last, input ready);
  modport sink   (input valid, status, result_id, fired, is_scheduled, last, output ready);
endinterface

/* sv/ptsc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/periodic_timer_scheduler_core.sv */
// Periodic timer scheduler: table of timers scanned by one shared compare unit.
// Depends on ptsc_pkg, ptsc_req_if, ptsc_rsp_if and ptsc_ram.
//
// Usage: requests arrive on req (valid/ready); each transaction is one of
// schedule, set period, add period, restart, cancel, query or tick. Results
// leave on rsp (valid/ready) from an output register. Every request but tick
// gives one result; a tick gives one result per timer fired (up to 16), in
// due-time order, or one plain result if nothing fires. last marks the final
// result of a request.
// Each slot scan reads one table entry per cycle; a bad count skips the scan,
// and a tick runs one scan per fired timer plus a closing scan unless the fire
// limit ends it. When a tie-order counter runs out, a renumbering pass is
// inserted. The table RAM read port sets this rate. One request is in flight
// at a time; req.ready is high only while idle, and an idle block accepts a
// request even if a result still waits.
// A stalled receiver holds the output register and the sequencer waits on it.
// Reset (synchronous) clears time, ids, tie order and all slot valid bits and
// drops any pending result; no clearing pass over the table is needed.
module periodic_timer_scheduler_core #(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_BITS  = 48
) (
  input  logic           clk,
  input  logic           rst,
  ptsc_req_if.sink       req,
  ptsc_rsp_if.source     rsp
);

  localparam int IW    = $clog2(NUM_TIMERS);
  localparam int CW    = IW + 1;
  localparam int REC_W = ptsc_pkg::ID_W + ptsc_pkg::PERIOD_W + ptsc_pkg::TIMES_W + TIME_BITS;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_DECIDE  = 4'd2;
  localparam logic [3:0] S_ORDER   = 4'd3;
  localparam logic [3:0] S_EMIT    = 4'd4;
  localparam logic [3:0] S_TLOOP   = 4'd5;
  localparam logic [3:0] S_FIRE    = 4'd6;
  localparam logic [3:0] S_REN_DEC = 4'd7;
  localparam logic [3:0] S_TFIN    = 4'd8;

  localparam logic [1:0] M_FREE = 2'd0;
  localparam logic [1:0] M_ID   = 2'd1;
  localparam logic [1:0] M_TICK = 2'd2;
  localparam logic [1:0] M_REN  = 2'd3;

  function automatic logic [TIME_BITS-1:0] due_add(input logic [TIME_BITS-1:0] b,
                                                   input logic signed [31:0] d);
    logic signed [TIME_BITS+1:0] s;
    s = $signed({2'b00, b}) + $signed({{(TIME_BITS-30){d[31]}}, d});
    if (s[TIME_BITS+1]) begin
      due_add = '0;
    end else if (s[TIME_BITS]) begin
      due_add = '1;
    end else begin
      due_add = s[TIME_BITS-1:0];
    end
  endfunction

  logic [3:0]                st, ret_st;
  logic [1:0]                md;
  logic [CW-1:0]             cnt;
  logic                      rd_vld;
  logic [IW-1:0]             rd_idx;

  logic [TIME_BITS-1:0]      cur;
  logic [15:0]               next_id;
  logic [ptsc_pkg::ORD_W-1:0] ins;
  logic [NUM_TIMERS-1:0]     valid, pend, rmark;

  ptsc_pkg::req_type_t       q_type;
  logic [15:0]               q_id;
  logic signed [31:0]        q_per;
  logic signed [16:0]        q_times;

  logic                      found;
  logic [IW-1:0]             s_idx;
  logic [15:0]               cap_id;
  logic signed [31:0]        cap_per;
  logic signed [16:0]        cap_rem;
  logic [TIME_BITS-1:0]      cap_due;
  logic [ptsc_pkg::ORD_W-1:0] cap_ord;

  logic                      rn_found;
  logic [IW-1:0]             rn_idx;
  logic [ptsc_pkg::ORD_W-1:0] rn_ord;
  logic [ptsc_pkg::ORD_W-1:0] rn_cnt;

  logic [ptsc_pkg::FCNT_W-1:0] n_fire;
  logic                      held;
  logic [15:0]               held_id;

  logic                      out_v;
  ptsc_pkg::status_t         out_status, e_status;
  logic [15:0]               out_id, e_id;
  logic                      out_fired, out_sched, out_last;
  logic                      e_fired, e_sched, e_last;

  // table RAM ports
  logic                      rec_we;
  logic [REC_W-1:0]          rec_wdata, rec_rdata;
  logic                      ord_we;
  logic [IW-1:0]             ord_waddr;
  logic [ptsc_pkg::ORD_W-1:0] ord_wdata, ord_rdata;

  logic [15:0]               rd_id;
  logic [TIME_BITS-1:0]      rd_due;

  logic [TIME_BITS-1:0]      du_b, du;
  logic signed [31:0]        du_d;
  logic signed [32:0]        np;
  logic                      np_ok;
  logic signed [16:0]        rem_dec;
  logic                      times_ok;

  ptsc_ram #(.WIDTH(REC_W), .DEPTH(NUM_TIMERS)) u_rec_ram (
    .clk(clk), .we(rec_we), .waddr(s_idx), .wdata(rec_wdata),
    .raddr(cnt[IW-1:0]), .rdata(rec_rdata)
  );

  ptsc_ram #(.WIDTH(ptsc_pkg::ORD_W), .DEPTH(NUM_TIMERS)) u_ord_ram (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(cnt[IW-1:0]), .rdata(ord_rdata)
  );

  assign rd_id  = rec_rdata[REC_W-1 -: 16];
  assign rd_due = rec_rdata[TIME_BITS-1:0];

  assign np      = {cap_per[31], cap_per} + {q_per[31], q_per};
  assign np_ok   = (np[32:31] == 2'b00);
  assign rem_dec = cap_rem - 17'sd1;

  assign times_ok = (!req.execute_times[16] && (req.execute_times != '0))
                    || (req.execute_times == '1);

  // shared saturating due-time adder
  always_comb begin
    du_b = cur;
    du_d = q_per;
    if (st == S_FIRE) begin
      du_b = cap_due;
      du_d = cap_per;
    end else if (q_type == ptsc_pkg::REQ_ADD) begin
      du_b = cap_due;
    end else if (q_type == ptsc_pkg::REQ_RESTART) begin
      du_d = cap_per;
    end
    du = due_add(du_b, du_d);
  end

  always_comb begin
    rec_we    = 1'b0;
    rec_wdata = {cap_id, cap_per, cap_rem, du};
    if (st == S_DECIDE && found) begin
      case (q_type)
        ptsc_pkg::REQ_SCHED: begin
          rec_we    = 1'b1;
          rec_wdata = {next_id, q_per, q_times, du};
        end
        ptsc_pkg::REQ_SET: begin
          rec_we    = !q_per[31];
          rec_wdata = {cap_id, q_per, q_times, du};
        end
        ptsc_pkg::REQ_ADD: begin
          rec_we    = np_ok;
          rec_wdata = {cap_id, np[31:0], q_times, du};
        end
        ptsc_pkg::REQ_RESTART: begin
          rec_we    = 1'b1;
        end
        default: begin
          rec_we    = 1'b0;
        end
      endcase
    end else if (st == S_FIRE) begin
      rec_we = (cap_rem != 17'sd1);
      if (cap_rem != -17'sd1) begin
        rec_wdata = {cap_id, cap_per, rem_dec, du};
      end
    end
  end

  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = s_idx;
    ord_wdata = ins;
    if (st == S_ORDER && ins != '1) begin
      ord_we = 1'b1;
    end else if (st == S_REN_DEC && rn_found) begin
      ord_we    = 1'b1;
      ord_waddr = rn_idx;
      ord_wdata = rn_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= S_IDLE;
      out_v   <= 1'b0;
      rd_vld  <= 1'b0;
      cur     <= '0;
      next_id <= 16'd1;
      ins     <= '0;
      valid   <= '0;
    end else begin
      if (out_v && rsp.ready && st != S_EMIT) begin
        out_v <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (req.valid) begin
            q_type  <= req.req_type;
            q_id    <= req.task_id;
            q_per   <= req.period_ms;
            q_times <= req.execute_times;
            cnt     <= '0;
            found   <= 1'b0;
            e_status <= ptsc_pkg::ST_BADARG;
            e_id     <= '0;
            e_fired  <= 1'b0;
            e_sched  <= 1'b0;
            e_last   <= 1'b1;
            ret_st   <= S_IDLE;
            case (req.req_type)
              ptsc_pkg::REQ_SCHED: begin
                md <= M_FREE;
                st <= times_ok ? S_SCAN : S_EMIT;
              end
              ptsc_pkg::REQ_SET, ptsc_pkg::REQ_ADD: begin
                md <= M_ID;
                st <= times_ok ? S_SCAN : S_EMIT;
              end
              ptsc_pkg::REQ_RESTART, ptsc_pkg::REQ_CANCEL, ptsc_pkg::REQ_QUERY: begin
                md <= M_ID;
                st <= S_SCAN;
              end
              ptsc_pkg::REQ_TICK: begin
                if (cur != '1) begin
                  cur <= cur + 1'b1;
                end
                pend   <= valid;
                n_fire <= '0;
                held   <= 1'b0;
                st     <= S_TLOOP;
              end
              default: begin
                st <= S_EMIT;
              end
            endcase
          end
        end

        S_SCAN: begin
          rd_vld <= (cnt != CW'(NUM_TIMERS));
          if (cnt != CW'(NUM_TIMERS)) begin
            rd_idx <= cnt[IW-1:0];
            cnt    <= cnt + 1'b1;
          end
          if (rd_vld) begin
            case (md)
              M_FREE: begin
                if (!found && !valid[rd_idx]) begin
                  found <= 1'b1;
                  s_idx <= rd_idx;
                end
              end
              M_ID: begin
                if (!found && valid[rd_idx] && rd_id == q_id) begin
                  found   <= 1'b1;
                  s_idx   <= rd_idx;
                  {cap_id, cap_per, cap_rem, cap_due} <= rec_rdata;
                end
              end
              M_TICK: begin
                if (pend[rd_idx] && rd_due <= cur &&
                    (!found || rd_due < cap_due || (rd_due == cap_due && ord_rdata > cap_ord))) begin
                  found   <= 1'b1;
                  s_idx   <= rd_idx;
                  cap_ord <= ord_rdata;
                  {cap_id, cap_per, cap_rem, cap_due} <= rec_rdata;
                end
              end
              default: begin
                if (rmark[rd_idx] && (!rn_found || ord_rdata < rn_ord)) begin
                  rn_found <= 1'b1;
                  rn_idx   <= rd_idx;
                  rn_ord   <= ord_rdata;
                end
              end
            endcase
          end
          if (cnt == CW'(NUM_TIMERS) && !rd_vld) begin
            st <= (md == M_REN) ? S_REN_DEC : S_DECIDE;
          end
        end

        S_DECIDE: begin
          st       <= S_EMIT;
          e_status <= ptsc_pkg::ST_NOTFOUND;
          case (q_type)
            ptsc_pkg::REQ_SCHED: begin
              if (!found) begin
                e_status <= ptsc_pkg::ST_FULL;
              end else begin
                valid[s_idx] <= 1'b1;
                e_id         <= next_id;
                next_id      <= (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
                st           <= S_ORDER;
              end
            end
            ptsc_pkg::REQ_SET: begin
              if (found) begin
                if (q_per[31]) begin
                  e_status <= ptsc_pkg::ST_BADARG;
                end else begin
                  st <= S_ORDER;
                end
              end
            end
            ptsc_pkg::REQ_ADD: begin
              if (found) begin
                e_status <= np_ok ? ptsc_pkg::ST_OK : ptsc_pkg::ST_BADARG;
              end
            end
            ptsc_pkg::REQ_RESTART: begin
              if (found) begin
                st <= S_ORDER;
              end
            end
            ptsc_pkg::REQ_CANCEL: begin
              if (found) begin
                valid[s_idx] <= 1'b0;
                e_status     <= ptsc_pkg::ST_OK;
              end
            end
            ptsc_pkg::REQ_QUERY: begin
              e_status <= ptsc_pkg::ST_OK;
              e_sched  <= found;
            end
            default: begin
              // tick: report the previous fire before handling this one
              if (!found) begin
                st <= S_TFIN;
              end else if (held) begin
                e_status <= ptsc_pkg::ST_OK;
                e_id     <= held_id;
                e_fired  <= 1'b1;
                e_last   <= 1'b0;
                ret_st   <= S_FIRE;
              end else begin
                st <= S_FIRE;
              end
            end
          endcase
        end

        S_FIRE: begin
          pend[s_idx] <= 1'b0;
          held        <= 1'b1;
          held_id     <= cap_id;
          n_fire      <= n_fire + 1'b1;
          if (cap_rem == 17'sd1) begin
            valid[s_idx] <= 1'b0;
            st           <= S_TLOOP;
          end else begin
            st <= S_ORDER;
          end
        end

        S_ORDER: begin
          if (ins == '1) begin
            rmark    <= valid;
            rn_cnt   <= '0;
            rn_found <= 1'b0;
            cnt      <= '0;
            md       <= M_REN;
            st       <= S_SCAN;
          end else begin
            ins <= ins + 1'b1;
            if (q_type == ptsc_pkg::REQ_TICK) begin
              st <= S_TLOOP;
            end else begin
              e_status <= ptsc_pkg::ST_OK;
              ret_st   <= S_IDLE;
              st       <= S_EMIT;
            end
          end
        end

        S_REN_DEC: begin
          if (rn_found) begin
            rmark[rn_idx] <= 1'b0;
            rn_cnt        <= rn_cnt + 1'b1;
            rn_found      <= 1'b0;
            cnt           <= '0;
            st            <= S_SCAN;
          end else begin
            ins <= rn_cnt;
            st  <= S_ORDER;
          end
        end

        S_TLOOP: begin
          if (n_fire == ptsc_pkg::FCNT_W'(ptsc_pkg::MAX_FIRES)) begin
            st <= S_TFIN;
          end else begin
            cnt   <= '0;
            found <= 1'b0;
            md    <= M_TICK;
            st    <= S_SCAN;
          end
        end

        S_TFIN: begin
          e_status <= ptsc_pkg::ST_OK;
          e_id     <= held ? held_id : 16'd0;
          e_fired  <= held;
          e_sched  <= 1'b0;
          e_last   <= 1'b1;
          ret_st   <= S_IDLE;
          st       <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_v || rsp.ready) begin
            out_v      <= 1'b1;
            out_status <= e_status;
            out_id     <= e_id;
            out_fired  <= e_fired;
            out_sched  <= e_sched;
            out_last   <= e_last;
            st         <= ret_st;
          end else begin
            out_v <= out_v;
          end
        end

        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (st == S_IDLE);
  assign rsp.valid        = out_v;
  assign rsp.status       = out_status;
  assign rsp.result_id    = out_id;
  assign rsp.fired        = out_fired;
  assign rsp.is_scheduled = out_sched;
  assign rsp.last         = out_last;

endmodule

/* sv/ptsc_checker.sv */
// Port-level checks for the timer scheduler, bound to the top level.
// Depends on ptsc_pkg and periodic_timer_scheduler_core_macros.svh.
`include "periodic_timer_scheduler_core_macros.svh"

module ptsc_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input ptsc_pkg::status_t   rsp_status,
  input logic [15:0]         rsp_result_id,
  input logic                rsp_fired,
  input logic                rsp_is_scheduled,
  input logic                rsp_last
);

  // a result waiting on the receiver stays up
  `PTSC_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

  // one request at a time: busy right after a transaction
  `PTSC_ASSERT_NXT(a_busy_after_req, clk, rst, req_valid && req_ready, !req_ready)

  // fire reports are ok and carry a live id
  `PTSC_ASSERT_IMP(a_fire_ok, clk, rst, rsp_valid && rsp_fired,
                   rsp_status == ptsc_pkg::ST_OK && rsp_result_id != 16'd0)

  // a query hit is a single plain result
  `PTSC_ASSERT_IMP(a_query_last, clk, rst, rsp_valid && rsp_is_scheduled,
                   !rsp_fired && rsp_last && rsp_status == ptsc_pkg::ST_OK)

endmodule

bind periodic_timer_scheduler_core ptsc_checker u_ptsc_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_result_id    (rsp.result_id),
  .rsp_fired        (rsp.fired),
  .rsp_is_scheduled (rsp.is_scheduled),
  .rsp_last         (rsp.last)
);
